// ----- src/mrfc_pkg.sv -----
`default_nettype none

package mrfc_pkg;

  // Bytes counted per buffer before the position saturates
  localparam int unsigned MaxBufferBytes = 512;
  localparam int unsigned PosW  = $clog2(MaxBufferBytes + 1);
  localparam int unsigned LenW  = 9;
  localparam int unsigned CmpW  = ((PosW > LenW) ? PosW : LenW) + 1;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [PosW-1:0] PosMax = PosW'(MaxBufferBytes);
  localparam logic [CmpW-1:0] MinFrameBytes = CmpW'(5);

  localparam logic [7:0] FcReadCoils     = 8'h01;
  localparam logic [7:0] FcReadHoldRegs  = 8'h03;
  localparam logic [7:0] FcWriteCoil     = 8'h05;
  localparam logic [7:0] FcWriteReg      = 8'h06;
  localparam logic [7:0] FcWriteCoils    = 8'h0F;
  localparam logic [7:0] FcWriteRegs     = 8'h10;

  localparam logic [LenW-1:0] FixedFrameLen = LenW'(8);
  localparam logic [LenW-1:0] RespHdrLen    = LenW'(5);
  localparam logic [LenW-1:0] CmdHdrLen     = LenW'(9);

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_SHORT      = 3'd1,
    ERR_FUNC       = 3'd2,
    ERR_INCOMPLETE = 3'd3,
    ERR_CRC        = 3'd4
  } err_e;

  typedef struct packed {
    logic            ok;
    err_e            err;
    logic [LenW-1:0] len;
  } verdict_t;

  // One byte of the reflected CRC-16, unrolled over its eight bits
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic fc_supported(input logic [7:0] fc);
    return (fc == FcReadCoils) || (fc == FcReadHoldRegs) || (fc == FcWriteCoil) ||
           (fc == FcWriteReg) || (fc == FcWriteCoils) || (fc == FcWriteRegs);
  endfunction

endpackage

`default_nettype wire

// ----- src/mrfc_tracker.sv -----
`default_nettype none

module mrfc_tracker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              is_response_i,
  input  wire logic              last_byte_i,
  output logic                   res_valid_o,
  output mrfc_pkg::verdict_t     res_o
);

  logic [mrfc_pkg::PosW-1:0] pos_q, pos_d, pos_nxt;
  logic [7:0]                fc_q, fc_d, fc_nxt;
  logic [mrfc_pkg::LenW-1:0] goal_q, goal_d, goal_nxt;
  logic [15:0]               crc_q, crc_d, crc_nxt;
  logic [15:0]               cap_q, cap_d, cap_nxt;
  logic                      resp_q, resp_d, resp_nxt;

  logic [mrfc_pkg::CmpW-1:0] p_w, goal_w, n_w, goal_nxt_w;
  logic                      counting;
  logic                      fc_is_read, fc_is_multi;

  always_comb begin
    p_w      = mrfc_pkg::CmpW'(pos_q);
    goal_w   = mrfc_pkg::CmpW'(goal_q);
    counting = (pos_q < mrfc_pkg::PosMax);

    pos_nxt  = pos_q;
    fc_nxt   = fc_q;
    goal_nxt = goal_q;
    crc_nxt  = crc_q;
    cap_nxt  = cap_q;
    resp_nxt = resp_q;

    fc_is_read  = (fc_q == mrfc_pkg::FcReadCoils) || (fc_q == mrfc_pkg::FcReadHoldRegs);
    fc_is_multi = (fc_q == mrfc_pkg::FcWriteCoils) || (fc_q == mrfc_pkg::FcWriteRegs);

    if (counting) begin
      // CRC covers everything up to the trailing two bytes of the expected frame
      if ((goal_q == '0) || ((p_w + mrfc_pkg::CmpW'(2)) < goal_w)) begin
        crc_nxt = mrfc_pkg::crc_byte(crc_q, data_byte_i);
      end else if (p_w == (goal_w - mrfc_pkg::CmpW'(2))) begin
        cap_nxt[7:0] = data_byte_i;
      end else if (p_w == (goal_w - mrfc_pkg::CmpW'(1))) begin
        cap_nxt[15:8] = data_byte_i;
      end

      if (pos_q == mrfc_pkg::PosW'(0)) begin
        resp_nxt = is_response_i;
      end
      if (pos_q == mrfc_pkg::PosW'(1)) begin
        fc_nxt = data_byte_i;
        if ((data_byte_i == mrfc_pkg::FcWriteCoil) ||
            (data_byte_i == mrfc_pkg::FcWriteReg)) begin
          goal_nxt = mrfc_pkg::FixedFrameLen;
        end else if ((data_byte_i == mrfc_pkg::FcReadCoils) ||
                     (data_byte_i == mrfc_pkg::FcReadHoldRegs)) begin
          goal_nxt = resp_q ? '0 : mrfc_pkg::FixedFrameLen;
        end else if ((data_byte_i == mrfc_pkg::FcWriteCoils) ||
                     (data_byte_i == mrfc_pkg::FcWriteRegs)) begin
          goal_nxt = resp_q ? mrfc_pkg::FixedFrameLen : '0;
        end else begin
          goal_nxt = '0;
        end
      end
      // byte count field sets the length of variable frames
      if ((pos_q == mrfc_pkg::PosW'(2)) && resp_q && fc_is_read) begin
        goal_nxt = mrfc_pkg::RespHdrLen + mrfc_pkg::LenW'(data_byte_i);
      end
      if ((pos_q == mrfc_pkg::PosW'(6)) && !resp_q && fc_is_multi) begin
        goal_nxt = mrfc_pkg::CmdHdrLen + mrfc_pkg::LenW'(data_byte_i);
      end
      pos_nxt = pos_q + mrfc_pkg::PosW'(1);
    end

    n_w        = mrfc_pkg::CmpW'(pos_nxt);
    goal_nxt_w = mrfc_pkg::CmpW'(goal_nxt);

    res_o = '{ok: 1'b0, err: mrfc_pkg::ERR_NONE, len: '0};
    if (n_w < mrfc_pkg::MinFrameBytes) begin
      res_o.err = mrfc_pkg::ERR_SHORT;
    end else if (!mrfc_pkg::fc_supported(fc_nxt)) begin
      res_o.err = mrfc_pkg::ERR_FUNC;
    end else if (goal_nxt == '0) begin
      res_o.err = mrfc_pkg::ERR_INCOMPLETE;
    end else if (goal_nxt_w > n_w) begin
      res_o.err = mrfc_pkg::ERR_INCOMPLETE;
      res_o.len = goal_nxt;
    end else begin
      res_o.len = goal_nxt;
      if (cap_nxt == crc_nxt) begin
        res_o.ok = 1'b1;
      end else begin
        res_o.err = mrfc_pkg::ERR_CRC;
      end
    end
    res_valid_o = accept_i && last_byte_i;

    pos_d  = pos_q;
    fc_d   = fc_q;
    goal_d = goal_q;
    crc_d  = crc_q;
    cap_d  = cap_q;
    resp_d = resp_q;
    if (accept_i) begin
      if (last_byte_i) begin
        pos_d  = '0;
        fc_d   = '0;
        goal_d = '0;
        crc_d  = mrfc_pkg::CrcInit;
        cap_d  = '0;
        resp_d = 1'b0;
      end else begin
        pos_d  = pos_nxt;
        fc_d   = fc_nxt;
        goal_d = goal_nxt;
        crc_d  = crc_nxt;
        cap_d  = cap_nxt;
        resp_d = resp_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      fc_q   <= '0;
      goal_q <= '0;
      crc_q  <= mrfc_pkg::CrcInit;
      cap_q  <= '0;
      resp_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      fc_q   <= fc_d;
      goal_q <= goal_d;
      crc_q  <= crc_d;
      cap_q  <= cap_d;
      resp_q <= resp_d;
    end
  end

  a_pos_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= mrfc_pkg::PosMax)
    else $error("byte position beyond saturation limit");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && last_byte_i) |=> (pos_q == '0 && goal_q == '0 &&
                                   crc_q == mrfc_pkg::CrcInit))
    else $error("state not cleared after last byte");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> ($stable(pos_q) && $stable(crc_q) && $stable(goal_q)))
    else $error("state moved without a transaction");

endmodule

`default_nettype wire

// ----- src/mrfc_out_reg.sv -----
`default_nettype none

module mrfc_out_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               res_valid_i,
  input  wire mrfc_pkg::verdict_t res_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output mrfc_pkg::verdict_t      out_o
);

  logic               valid_q, valid_d;
  mrfc_pkg::verdict_t res_q;
  logic               load;

  // register frees up in the same cycle its verdict is taken
  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_ready_o && res_valid_i;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while verdict stalled");

endmodule

`default_nettype wire

// ----- src/modbus_rtu_frame_checker.sv -----
// Modbus RTU frame checker.
// Slave channel: one buffer byte per transaction on s_axis_tdata_i, tlast on the
// buffer's final byte, tuser (response rules when high) sampled on the first byte.
// Master channel: one verdict per buffer, after the transaction carrying tlast.
// Expected length comes from the function code and, for variable frames, the byte
// count; CRC-16 (init FFFF, reflected poly A001) runs over the frame bar its last
// two bytes, which are compared as the received CRC, low byte first.
// Throughput: one byte per cycle when not stalled; the whole CRC byte update and
// length logic sit between the state registers and the verdict register.
// Latency: the verdict is valid the cycle after the last byte is taken.
// Bytes beyond the saturation count (512) are accepted and ignored; bytes past
// the expected frame length are accepted and ignored.
// Reset: all buffer state clears and no verdict is pending; state also clears
// after every last byte.
// Stall: while the verdict register is full and m_axis_tready_i is low,
// s_axis_tready_o is low, so no byte at all is taken until the verdict leaves.
`default_nettype none

module modbus_rtu_frame_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tuser_i,   // [0] is_response
  input  wire logic        s_axis_tlast_i,   // last_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [8:0] expected_length, [15:9] zero
  output logic [3:0]       m_axis_tuser_o    // [0] frame_ok, [3:1] error_kind
);

  logic               accept;
  logic               res_valid;
  mrfc_pkg::verdict_t res, out;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  mrfc_tracker u_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (s_axis_tdata_i),
    .is_response_i (s_axis_tuser_i),
    .last_byte_i   (s_axis_tlast_i),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  mrfc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (out)
  );

  assign m_axis_tdata_o = {(16 - mrfc_pkg::LenW)'(0), out.len};
  assign m_axis_tuser_o = {out.err, out.ok};

  a_ok_means_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (out.err == mrfc_pkg::ERR_NONE))
    else $error("frame_ok with an error kind");

  a_early_errors_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out.err == mrfc_pkg::ERR_SHORT ||
                         out.err == mrfc_pkg::ERR_FUNC)) |-> (out.len == '0))
    else $error("length reported on short buffer or unknown function");

  a_verdict_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast_i) |=> m_axis_tvalid_o)
    else $error("no verdict after last byte");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int HoldCycles = 400;

  localparam logic [7:0] KnownFcs [6] = '{mrfc_pkg::FcReadCoils, mrfc_pkg::FcReadHoldRegs,
                                          mrfc_pkg::FcWriteCoil, mrfc_pkg::FcWriteReg,
                                          mrfc_pkg::FcWriteCoils, mrfc_pkg::FcWriteRegs};

  // One directed buffer; want is only meaningful when typed is set
  typedef struct packed {
    logic               resp;
    logic [7:0]         fc;
    int                 count;
    int                 len;
    logic               corrupt;
    logic               typed;
    mrfc_pkg::verdict_t want;
  } buf_case_t;

  localparam mrfc_pkg::verdict_t NoVerdict = '{1'b0, mrfc_pkg::ERR_NONE, 9'd0};

  // 8'h00 and 8'hFF stand for function codes the block does not know
  localparam buf_case_t DirCases [17] = '{
    '{1'b0, mrfc_pkg::FcReadHoldRegs, 0,   8,  1'b0, 1'b1,
      '{1'b1, mrfc_pkg::ERR_NONE, 9'd8}},
    '{1'b0, mrfc_pkg::FcWriteReg,     0,   8,  1'b1, 1'b1,
      '{1'b0, mrfc_pkg::ERR_CRC, 9'd8}},
    '{1'b0, mrfc_pkg::FcWriteCoil,    0,   1,  1'b0, 1'b1,
      '{1'b0, mrfc_pkg::ERR_SHORT, 9'd0}},
    '{1'b1, mrfc_pkg::FcReadCoils,    0,   4,  1'b0, 1'b1,
      '{1'b0, mrfc_pkg::ERR_SHORT, 9'd0}},
    '{1'b0, 8'h00,                    0,   8,  1'b0, 1'b1,
      '{1'b0, mrfc_pkg::ERR_FUNC, 9'd0}},
    '{1'b1, 8'hFF,                    0,   8,  1'b0, 1'b1,
      '{1'b0, mrfc_pkg::ERR_FUNC, 9'd0}},
    '{1'b0, mrfc_pkg::FcWriteCoils,   3,   6,  1'b0, 1'b1,
      '{1'b0, mrfc_pkg::ERR_INCOMPLETE, 9'd0}},
    '{1'b1, mrfc_pkg::FcReadHoldRegs, 4,   5,  1'b0, 1'b1,
      '{1'b0, mrfc_pkg::ERR_INCOMPLETE, 9'd9}},
    '{1'b0, mrfc_pkg::FcWriteCoil,    0,   7,  1'b0, 1'b1,
      '{1'b0, mrfc_pkg::ERR_INCOMPLETE, 9'd8}},
    '{1'b1, mrfc_pkg::FcReadHoldRegs, 255, 5,  1'b0, 1'b1,
      '{1'b0, mrfc_pkg::ERR_INCOMPLETE, 9'd260}},
    '{1'b0, mrfc_pkg::FcWriteRegs,    255, 7,  1'b0, 1'b1,
      '{1'b0, mrfc_pkg::ERR_INCOMPLETE, 9'd264}},
    '{1'b0, mrfc_pkg::FcWriteCoils,   0,   9,  1'b0, 1'b0, NoVerdict},
    '{1'b1, mrfc_pkg::FcReadCoils,    0,   5,  1'b1, 1'b0, NoVerdict},
    '{1'b1, mrfc_pkg::FcWriteRegs,    0,   8,  1'b0, 1'b0, NoVerdict},
    '{1'b1, mrfc_pkg::FcWriteCoil,    0,   8,  1'b0, 1'b0, NoVerdict},
    '{1'b0, mrfc_pkg::FcReadCoils,    0,   20, 1'b0, 1'b0, NoVerdict},
    '{1'b0, mrfc_pkg::FcWriteCoils,   2,   11, 1'b1, 1'b0, NoVerdict}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = 8'h00;
  logic        s_user = 1'b0;
  logic        s_last = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;
  logic [3:0]  m_axis_tuser_o;

  modbus_rtu_frame_checker uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Frame-tracking state of the checker as predicted here
  int unsigned pos;
  int unsigned goal;
  logic [7:0]  fcode;
  logic [15:0] crc_run;
  logic [15:0] crc_got;
  logic        resp_mode;

  mrfc_pkg::verdict_t verdicts[$];
  logic [7:0]         frame_bytes[$];
  logic               use_typed = 1'b0;
  mrfc_pkg::verdict_t typed_want;
  int                 n_errors = 0;
  int                 bytes_sent = 0;
  int                 src_idle = 0;
  int                 sink_stall = 0;
  int                 hold_asked = 0;
  int                 hold_done = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    return r;
  endfunction

  function automatic void clear_frame();
    pos = 0;
    goal = 0;
    fcode = 8'h00;
    crc_run = 16'hFFFF;
    crc_got = 16'h0000;
    resp_mode = 1'b0;
  endfunction

  // Advances the predicted state by one accepted byte; queues a verdict on tlast
  function automatic void take_byte(input logic [7:0] b, input logic r, input logic l);
    mrfc_pkg::verdict_t v;
    if (pos < mrfc_pkg::MaxBufferBytes) begin
      if (goal == 0 || pos + 2 < goal) crc_run = crc16_step(crc_run, b);
      else if (pos == goal - 2) crc_got[7:0] = b;
      else if (pos == goal - 1) crc_got[15:8] = b;
      if (pos == 0) resp_mode = r;
      if (pos == 1) begin
        fcode = b;
        if (b == mrfc_pkg::FcWriteCoil || b == mrfc_pkg::FcWriteReg) goal = 8;
        else if (b == mrfc_pkg::FcReadCoils || b == mrfc_pkg::FcReadHoldRegs)
          goal = resp_mode ? 0 : 8;
        else if (b == mrfc_pkg::FcWriteCoils || b == mrfc_pkg::FcWriteRegs)
          goal = resp_mode ? 8 : 0;
        else goal = 0;
      end
      if (pos == 2 && resp_mode &&
          (fcode == mrfc_pkg::FcReadCoils || fcode == mrfc_pkg::FcReadHoldRegs))
        goal = 5 + b;
      if (pos == 6 && !resp_mode &&
          (fcode == mrfc_pkg::FcWriteCoils || fcode == mrfc_pkg::FcWriteRegs))
        goal = 9 + b;
      pos++;
    end
    if (!l) return;
    v = NoVerdict;
    if (pos < 5) v.err = mrfc_pkg::ERR_SHORT;
    else if (!(fcode inside {KnownFcs})) v.err = mrfc_pkg::ERR_FUNC;
    else if (goal == 0) v.err = mrfc_pkg::ERR_INCOMPLETE;
    else if (goal > pos) begin
      v.err = mrfc_pkg::ERR_INCOMPLETE;
      v.len = 9'(goal);
    end else begin
      v.len = 9'(goal);
      if (crc_got == crc_run) v.ok = 1'b1;
      else v.err = mrfc_pkg::ERR_CRC;
    end
    verdicts.push_back(use_typed ? typed_want : v);
    use_typed = 1'b0;
    clear_frame();
  endfunction

  function automatic int frame_len_of(input logic resp, input logic [7:0] fc,
                                      input int count);
    if (!(fc inside {KnownFcs})) return 0;
    if (resp && (fc == mrfc_pkg::FcReadCoils || fc == mrfc_pkg::FcReadHoldRegs))
      return 5 + count;
    if (!resp && (fc == mrfc_pkg::FcWriteCoils || fc == mrfc_pkg::FcWriteRegs))
      return 9 + count;
    return 8;
  endfunction

  // Fills frame_bytes with len bytes of a frame carrying a valid (or broken) CRC
  function automatic void build_frame(input logic resp, input logic [7:0] fc,
                                      input int count, input int len, input logic corrupt);
    int          flen;
    logic [15:0] c;
    flen = frame_len_of(resp, fc, count);
    frame_bytes.delete();
    for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom_range(255)));
    if (len > 1) frame_bytes[1] = fc;
    if (resp && (fc == mrfc_pkg::FcReadCoils || fc == mrfc_pkg::FcReadHoldRegs) && len > 2)
      frame_bytes[2] = 8'(count);
    if (!resp && (fc == mrfc_pkg::FcWriteCoils || fc == mrfc_pkg::FcWriteRegs) && len > 6)
      frame_bytes[6] = 8'(count);
    if (flen != 0) begin
      c = 16'hFFFF;
      for (int i = 0; i < flen - 2 && i < len; i++) c = crc16_step(c, frame_bytes[i]);
      if (flen - 2 < len)
        frame_bytes[flen-2] = c[7:0] ^ (corrupt ? 8'($urandom_range(255, 1)) : 8'h00);
      if (flen - 1 < len) frame_bytes[flen-1] = c[15:8];
    end
  endfunction

  // Mostly well-formed frames of random content; the rest is random noise
  function automatic logic make_random_frame();
    logic       resp;
    logic [7:0] fc;
    int         count, flen, len, sel;
    resp = 1'($urandom_range(1));
    if ($urandom_range(99) < 25) begin
      len = $urandom_range(12, 1);
      frame_bytes.delete();
      for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom_range(255)));
      return resp;
    end
    fc = KnownFcs[$urandom_range(5)];
    count = ($urandom_range(99) < 3) ? $urandom_range(255) : $urandom_range(10);
    flen = frame_len_of(resp, fc, count);
    sel = $urandom_range(99);
    if (sel < 70) len = flen;
    else if (sel < 82) len = flen + $urandom_range(6, 1);
    else len = flen - $urandom_range(4, 1);
    build_frame(resp, fc, count, len, $urandom_range(99) < 20);
    return resp;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic r, input logic l);
    while ($urandom_range(99) < src_idle) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= b;
    s_user <= r;
    s_last <= l;
    do @(posedge clk_i); while (!s_axis_tready_o);
    bytes_sent++;
    take_byte(b, r, l);
  endtask

  // tuser only matters on the first byte; elsewhere it is left to toggle freely
  task automatic send_buffer(input logic resp);
    foreach (frame_bytes[i])
      send_byte(frame_bytes[i], (i == 0) ? resp : 1'($urandom_range(1)),
                i == frame_bytes.size() - 1);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    while (verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_traffic(input int min_bytes, input int min_frames);
    int   start, frames;
    logic resp;
    start = bytes_sent;
    frames = 0;
    while (bytes_sent - start < min_bytes || frames < min_frames) begin
      resp = make_random_frame();
      send_buffer(resp);
      frames++;
    end
  endtask

  task automatic report(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    n_errors++;
  endtask

  // Receiver side: random stalls, or one long hold-off when asked for
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        for (int k = 0; k < HoldCycles; k++) begin
          m_tready <= 1'b0;
          @(posedge clk_i);
        end
      end else begin
        m_tready <= ($urandom_range(99) >= sink_stall);
      end
    end
  end

  always @(posedge clk_i) begin
    mrfc_pkg::verdict_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (verdicts.size() == 0) begin
        report("verdict with none pending");
      end else begin
        want = verdicts.pop_front();
        if (m_axis_tuser_o[0] !== want.ok)
          report($sformatf("frame_ok %b, want %b", m_axis_tuser_o[0], want.ok));
        if (m_axis_tuser_o[3:1] !== want.err)
          report($sformatf("error_kind %0d, want %0d", m_axis_tuser_o[3:1], want.err));
        if (m_axis_tdata_o[8:0] !== want.len)
          report($sformatf("expected_length %0d, want %0d", m_axis_tdata_o[8:0], want.len));
      end
    end
  end

  initial begin
    clear_frame();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirCases[i]) begin
      build_frame(DirCases[i].resp, DirCases[i].fc, DirCases[i].count, DirCases[i].len,
                  DirCases[i].corrupt);
      use_typed = DirCases[i].typed;
      typed_want = DirCases[i].want;
      send_buffer(DirCases[i].resp);
    end
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_idle = 63;
          sink_stall = 0;
        end
        1: begin
          // long hold-off with the sender still pushing: input must back up
          src_idle = 0;
          sink_stall = 63;
          hold_asked++;
        end
        2: begin
          src_idle = 10;
          sink_stall = 10;
        end
        default: begin
          src_idle = 0;
          sink_stall = 0;
        end
      endcase
      random_traffic(60, 6);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- modbus_rtu_frame_checker.f -----
src/mrfc_pkg.sv
src/mrfc_tracker.sv
src/mrfc_out_reg.sv
src/modbus_rtu_frame_checker.sv
bench/tb.sv
